@@ src/amount_to_voice_tracks_assert.svh @@
// Assertion macros shared by the checkers of the voice track block.
`ifndef AMOUNT_TO_VOICE_TRACKS_ASSERT_SVH
`define AMOUNT_TO_VOICE_TRACKS_ASSERT_SVH

// Same-cycle implication, masked while reset is high.
`define ATVT_ASSERT_NOW(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("voice track check failed");

// Next-cycle implication, masked while reset is high.
`define ATVT_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("voice track check failed");

// Condition that must hold in the cycle after reset is applied.
`define ATVT_ASSERT_AFTER_RESET(name, cons) \
   name: assert property (@(posedge clock) reset |=> (cons)) \
      else $error("voice track reset check failed");

`endif

@@ src/atvt_pkg.sv @@
// Shared types and constants of the amount to voice track block.
package atvt_pkg;

   localparam int AMOUNT_W       = 32;
   localparam int TRACK_W        = 5;
   localparam int DIGIT_W        = 4;
   localparam int NUM_DIGITS     = 10;
   localparam int BCD_W          = NUM_DIGITS * DIGIT_W;
   localparam int BITS_PER_STAGE = 4;
   localparam int NUM_STAGES     = AMOUNT_W / BITS_PER_STAGE;
   localparam int FIFO_DEPTH     = 2;
   localparam int PTR_W          = $clog2(FIFO_DEPTH);
   localparam int CNT_W          = $clog2(FIFO_DEPTH + 1);

   typedef logic signed [AMOUNT_W-1:0]          amount_type;
   typedef logic [TRACK_W-1:0]                  track_type;
   typedef logic [DIGIT_W-1:0]                  digit_type;
   typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0]  bcd_type;

   typedef struct packed {
      logic    valid;
      bcd_type digits;
   } bcd_xfer_type;

   localparam track_type TRK_TEN          = 5'd10;
   localparam track_type TRK_ELEVEN       = 5'd11;
   localparam track_type TRK_TEEN         = 5'd12;
   localparam track_type TRK_TENS         = 5'd13;
   localparam track_type TRK_ONE_HUNDRED  = 5'd14;
   localparam track_type TRK_HUNDRED      = 5'd15;
   localparam track_type TRK_ONE_THOUSAND = 5'd16;
   localparam track_type TRK_THOUSAND     = 5'd17;
   localparam track_type TRK_MILLION      = 5'd18;
   localparam track_type TRK_SUFFIX       = 5'd19;
   localparam track_type TRK_PREFIX       = 5'd20;

endpackage

@@ src/atvt_front.sv @@
// Front end: accepts amounts and converts them to decimal digits in a pipeline.
module atvt_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  atvt_pkg::amount_type req_amount,
   input  logic                 q_full,
   output atvt_pkg::bcd_xfer_type q_push
);
   import atvt_pkg::*;

   localparam int LAST = NUM_STAGES - 1;

   logic                  valid_ff [NUM_STAGES];
   logic                  valid_in [NUM_STAGES];
   bcd_type               bcd_ff   [NUM_STAGES];
   bcd_type               bcd_in   [NUM_STAGES];
   logic [AMOUNT_W-1:0]   bin_ff   [NUM_STAGES-1];
   logic [AMOUNT_W-1:0]   bin_in   [NUM_STAGES-1];
   logic [AMOUNT_W-1:0]   value;
   logic                  advance;

   // Shift-and-add-three conversion of one group of input bits, most significant first.
   function automatic bcd_type dd_nibble(bcd_type bcd_i, logic [BITS_PER_STAGE-1:0] bits);
      bcd_type          acc;
      logic [BCD_W-1:0] flat;
      acc = bcd_i;
      for (int b = BITS_PER_STAGE - 1; b >= 0; b--) begin
         for (int i = 0; i < NUM_DIGITS; i++) begin
            if (acc[i] >= 4'd5) begin
               acc[i] = acc[i] + 4'd3;
            end
         end
         flat = acc;
         flat = {flat[BCD_W-2:0], bits[b]};
         acc  = flat;
      end
      return acc;
   endfunction

   // A zero or negative amount is spoken as nothing, so it enters as zero.
   assign value   = req_amount[AMOUNT_W-1] ? '0 : req_amount;
   assign advance = !(valid_ff[LAST] && q_full);
   assign req_ready = advance;

   always_comb begin
      valid_in[0] = req_valid;
      bin_in[0]   = value;
      bcd_in[0]   = dd_nibble('0, value[AMOUNT_W-1 -: BITS_PER_STAGE]);
      for (int k = 1; k < NUM_STAGES; k++) begin
         valid_in[k] = valid_ff[k-1];
         bcd_in[k]   = dd_nibble(bcd_ff[k-1],
                                 bin_ff[k-1][AMOUNT_W-1-BITS_PER_STAGE*k -: BITS_PER_STAGE]);
      end
      for (int k = 1; k < NUM_STAGES - 1; k++) begin
         bin_in[k] = bin_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_STAGES; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (advance) begin
         for (int k = 0; k < NUM_STAGES; k++) begin
            valid_ff[k] <= valid_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < NUM_STAGES; k++) begin
            bcd_ff[k] <= bcd_in[k];
         end
         for (int k = 0; k < NUM_STAGES - 1; k++) begin
            bin_ff[k] <= bin_in[k];
         end
      end
   end

   assign q_push.valid  = valid_ff[LAST];
   assign q_push.digits = bcd_ff[LAST];

endmodule

@@ src/atvt_fifo.sv @@
// Short queue of converted amounts between the front end and the track sequencer.
module atvt_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  atvt_pkg::bcd_xfer_type q_push,
   output logic                   q_full,
   output logic                   head_valid,
   output atvt_pkg::bcd_type      head_digits,
   input  logic                   pop
);
   import atvt_pkg::*;

   bcd_type          mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic             push_en;
   logic             pop_en;

   assign q_full      = (cnt_ff == CNT_W'(FIFO_DEPTH));
   assign head_valid  = (cnt_ff != '0);
   assign head_digits = mem_ff[rd_ptr_ff];
   assign push_en     = q_push.valid && !q_full;
   assign pop_en      = pop && head_valid;

   always_comb begin
      wr_ptr_in = push_en ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop_en ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + CNT_W'(push_en) - CNT_W'(pop_en);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         mem_ff[wr_ptr_ff] <= q_push.digits;
      end
   end

endmodule

@@ src/atvt_back.sv @@
// Back end: walks an amount's phrases, one track per cycle while rsp_ready is high.
module atvt_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  atvt_pkg::bcd_type    head_digits,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output atvt_pkg::track_type  rsp_track,
   output logic                 rsp_last
);
   import atvt_pkg::*;

   localparam int MAX_TOKENS = 5;
   localparam int TOK_IDX_W  = $clog2(MAX_TOKENS);
   localparam int TOK_CNT_W  = $clog2(MAX_TOKENS + 1);
   localparam int NUM_SLOTS  = 8;
   localparam int SLOT_W     = $clog2(NUM_SLOTS);

   typedef logic [SLOT_W-1:0] slot_type;

   typedef struct packed {
      logic [MAX_TOKENS-1:0][TRACK_W-1:0] tok;
      logic [TOK_CNT_W-1:0]               cnt;
   } phrase_type;

   localparam slot_type SLOT_PREFIX    = 3'd0;
   localparam slot_type SLOT_MEGA_THOU = 3'd1;
   localparam slot_type SLOT_MEGA_LOW  = 3'd2;
   localparam slot_type SLOT_MILLION   = 3'd3;
   localparam slot_type SLOT_THOU      = 3'd4;
   localparam slot_type SLOT_THOU_WORD = 3'd5;
   localparam slot_type SLOT_UNITS     = 3'd6;
   localparam slot_type SLOT_SUFFIX    = 3'd7;

   function automatic phrase_type push(phrase_type p_i, track_type t);
      phrase_type p;
      p = p_i;
      p.tok[p.cnt[TOK_IDX_W-1:0]] = t;
      p.cnt = p.cnt + TOK_CNT_W'(1);
      return p;
   endfunction

   function automatic phrase_type single(track_type t);
      phrase_type p;
      p = '0;
      p = push(p, t);
      return p;
   endfunction

   // Words for a group below one thousand, given as hundreds, tens and units digits.
   function automatic phrase_type say_group(digit_type h, digit_type t, digit_type u);
      phrase_type p;
      p = '0;
      if (h == 4'd1) begin
         p = push(p, TRK_ONE_HUNDRED);
      end else if (h != 4'd0) begin
         p = push(p, track_type'(h));
         p = push(p, TRK_HUNDRED);
      end
      if (t == 4'd0) begin
         if (u != 4'd0) begin
            p = push(p, track_type'(u));
         end
      end else if (t == 4'd1) begin
         if (u == 4'd0) begin
            p = push(p, TRK_TEN);
         end else if (u == 4'd1) begin
            p = push(p, TRK_ELEVEN);
         end else begin
            p = push(p, track_type'(u));
            p = push(p, TRK_TEEN);
         end
      end else begin
         p = push(p, track_type'(t));
         p = push(p, TRK_TENS);
         if (u != 4'd0) begin
            p = push(p, track_type'(u));
         end
      end
      return p;
   endfunction

   phrase_type           ph [NUM_SLOTS];
   phrase_type           cur;
   slot_type             slot_ff;
   slot_type             slot_in;
   slot_type             next_slot;
   logic [TOK_IDX_W-1:0] idx_ff;
   logic [TOK_IDX_W-1:0] idx_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   track_type            track_ff;
   track_type            track_in;
   logic                 last_ff;
   logic                 last_in;
   logic                 load;
   logic                 emit;
   logic                 phrase_end;
   logic                 is_suffix;
   logic                 mega_nonzero;
   logic                 thou_zero;
   logic                 thou_one;

   assign mega_nonzero = (head_digits[9] != '0) || (head_digits[8] != '0)
                      || (head_digits[7] != '0) || (head_digits[6] != '0);
   assign thou_zero = (head_digits[5] == '0) && (head_digits[4] == '0)
                   && (head_digits[3] == '0);
   assign thou_one  = (head_digits[5] == '0) && (head_digits[4] == '0)
                   && (head_digits[3] == 4'd1);

   always_comb begin
      ph[SLOT_PREFIX] = single(TRK_PREFIX);
      if (head_digits[9] == 4'd1) begin
         ph[SLOT_MEGA_THOU] = single(TRK_ONE_THOUSAND);
      end else if (head_digits[9] != '0) begin
         ph[SLOT_MEGA_THOU] = push(say_group('0, '0, head_digits[9]), TRK_THOUSAND);
      end else begin
         ph[SLOT_MEGA_THOU] = '0;
      end
      ph[SLOT_MEGA_LOW]  = say_group(head_digits[8], head_digits[7], head_digits[6]);
      ph[SLOT_MILLION]   = mega_nonzero ? single(TRK_MILLION) : '0;
      ph[SLOT_THOU]      = thou_one ? single(TRK_ONE_THOUSAND)
                                    : say_group(head_digits[5], head_digits[4], head_digits[3]);
      ph[SLOT_THOU_WORD] = (!thou_zero && !thou_one) ? single(TRK_THOUSAND) : '0;
      ph[SLOT_UNITS]     = say_group(head_digits[2], head_digits[1], head_digits[0]);
      ph[SLOT_SUFFIX]    = single(TRK_SUFFIX);
   end

   always_comb begin
      next_slot = SLOT_SUFFIX;
      for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
         if (slot_type'(k) > slot_ff && ph[k].cnt != '0) begin
            next_slot = slot_type'(k);
         end
      end
   end

   assign cur        = ph[slot_ff];
   assign load       = !rsp_valid_ff || rsp_ready;
   assign emit       = load && head_valid;
   assign phrase_end = (TOK_CNT_W'(idx_ff) == cur.cnt - TOK_CNT_W'(1));
   assign is_suffix  = (slot_ff == SLOT_SUFFIX);
   assign pop        = emit && phrase_end && is_suffix;

   always_comb begin
      slot_in      = slot_ff;
      idx_in       = idx_ff;
      track_in     = track_ff;
      last_in      = last_ff;
      rsp_valid_in = load ? 1'b0 : rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         track_in     = cur.tok[idx_ff];
         last_in      = is_suffix;
         if (phrase_end) begin
            idx_in  = '0;
            slot_in = is_suffix ? SLOT_PREFIX : next_slot;
         end else begin
            idx_in = idx_ff + TOK_IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= SLOT_PREFIX;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         slot_ff      <= slot_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      track_ff <= track_in;
      last_ff  <= last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_track = track_ff;
   assign rsp_last  = last_ff;

endmodule

@@ src/amount_to_voice_tracks.sv @@
// Top level of the block that turns a money amount into Indonesian voice tracks.
//
// The req_ channel takes one signed 32-bit amount per transaction. The rsp_
// channel returns the voice tracks that announce it, one per transaction:
// prefix track 20, the word tracks, then suffix track 19 with rsp_last set.
// A zero or negative amount gives only the prefix and the suffix.
// An amount passes an eight-stage binary to decimal pipeline (four bits a
// stage), waits in a two-entry queue, and is then spoken by a sequencer that
// emits one track per cycle while rsp_ready stays high. An amount is spoken
// as 2 to 20 tracks, and that track count sets the sustained throughput.
// req_ready stays high while the last pipeline stage can move into the queue,
// so new amounts are taken while earlier ones are still being spoken.
// When the receiver holds rsp_ready low, the output register keeps its track,
// the queue fills and the pipeline then stalls as a whole.
// Synchronous reset empties the pipeline, the queue and the output register.
module amount_to_voice_tracks (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  atvt_pkg::amount_type req_amount,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output atvt_pkg::track_type  rsp_track,
   output logic                 rsp_last
);
   import atvt_pkg::*;

   bcd_xfer_type q_push;
   logic         q_full;
   logic         head_valid;
   bcd_type      head_digits;
   logic         pop;

   atvt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_amount (req_amount),
      .q_full     (q_full),
      .q_push     (q_push)
   );

   atvt_fifo u_fifo (
      .clock       (clock),
      .reset       (reset),
      .q_push      (q_push),
      .q_full      (q_full),
      .head_valid  (head_valid),
      .head_digits (head_digits),
      .pop         (pop)
   );

   atvt_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_digits (head_digits),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_track   (rsp_track),
      .rsp_last    (rsp_last)
   );

endmodule

@@ src/atvt_checker.sv @@
// Port-level checker of the voice track block and its bind to the top level.
`include "amount_to_voice_tracks_assert.svh"

module atvt_checker (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input atvt_pkg::track_type rsp_track,
   input logic                rsp_last
);
   import atvt_pkg::*;

   `ATVT_ASSERT_AFTER_RESET(a_idle_after_reset, !rsp_valid)
   `ATVT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_track) && $stable(rsp_last))
   `ATVT_ASSERT_NOW(a_last_is_suffix, rsp_valid, rsp_last == (rsp_track == TRK_SUFFIX))
   `ATVT_ASSERT_NEXT(a_prefix_follows, rsp_valid && rsp_ready && rsp_last, !rsp_valid || rsp_track == TRK_PREFIX)
   `ATVT_ASSERT_NOW(a_track_range, rsp_valid, rsp_track != '0 && rsp_track <= TRK_PREFIX)

endmodule

bind amount_to_voice_tracks atvt_checker u_atvt_checker (.*);
